// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcmr check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcmr check failed");

`endif

// File: rtl/core/rcmr_pkg.sv
// Package: sizes, codes and types shared by the rod cutting core.
package rcmr_pkg;

  localparam int unsigned MAX_LEN    = 16;
  localparam int unsigned PRICE_BITS = 16;
  localparam int unsigned REV_BITS   = 20;

  // Port widths fixed by the request format.
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned LEN_W      = 5;

  localparam int unsigned PADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned BADDR_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned SUM_W      = ((PRICE_BITS > REV_BITS) ? PRICE_BITS : REV_BITS) + 1;

  localparam logic [REV_BITS-1:0] REV_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                  we;
    logic [PADDR_W-1:0]    waddr;
    logic [PRICE_BITS-1:0] wdata;
    logic [PADDR_W-1:0]    raddr;
  } price_req_t;

  typedef struct packed {
    logic                we;
    logic [BADDR_W-1:0]  waddr;
    logic [REV_BITS-1:0] wdata;
    logic [BADDR_W-1:0]  raddr;
  } best_req_t;

endpackage

// File: rtl/core/rod_cutting_max_revenue_core.sv
// A query of length n (saturated to 16) walks rows and cuts on the RAMs as price/best
//   read-add-compare steps, one per cycle, and then fills the output register.
// A new request is taken only while the sequencer is idle; a load leaves it idle.
// Length zero: no walk, straight to the result. A finished result waits in the output register.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty, all prices read as zero.
// No clearing pass; the best table is rewritten by every query before it is read.
module rod_cutting_max_revenue_core
  import rcmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [IDX_W-1:0]    price_index_i,
  input  logic [VAL_W-1:0]    price_value_i,
  input  logic [LEN_W-1:0]    rod_length_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [REV_BITS-1:0] best_revenue_o
);

  // Memory request buses from the sequencer
  price_req_t            price_req;
  best_req_t             best_req;
  logic [PRICE_BITS-1:0] price_rdata;
  logic [REV_BITS-1:0]   best_rdata;

  // Sequencer: a load with index 1..16 writes one price; a query walks rows i = 1..n and
  // cuts j = 1..i, reading price[j] and best[i-j] together and keeping the max.
  rcmr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .price_index_i  (price_index_i),
    .price_value_i  (price_value_i),
    .rod_length_i   (rod_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_revenue_o (best_revenue_o),
    .price_req_o    (price_req),
    .price_rdata_i  (price_rdata),
    .best_req_o     (best_req),
    .best_rdata_i   (best_rdata)
  );

  // Price table, cleared by valid bits at reset
  rcmr_price_mem u_price_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (price_req),
    .rdata_o (price_rdata)
  );

  // Best-revenue table; the row end write is forwarded to the next row's first read
  rcmr_best_mem u_best_mem (
    .clk_i   (clk_i),
    .req_i   (best_req),
    .rdata_o (best_rdata)
  );

endmodule

// File: rtl/core/rcmr_price_mem.sv
// Price table: synchronous RAM with per-entry valid bits, unloaded entries read as zero.
module rcmr_price_mem
  import rcmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  price_req_t            req_i,
  output logic [PRICE_BITS-1:0] rdata_o
);

  logic [PRICE_BITS-1:0] mem [MAX_LEN];
  logic [MAX_LEN-1:0]    valid_q;
  logic [PRICE_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rcmr_best_mem.sv
// Best-revenue table: synchronous RAM, write-first on a same-address read.
module rcmr_best_mem
  import rcmr_pkg::*;
(
  input  logic                clk_i,
  input  best_req_t           req_i,
  output logic [REV_BITS-1:0] rdata_o
);

  logic [REV_BITS-1:0] mem [MAX_LEN + 1];
  logic [REV_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    // forward the entry being written; the next row reads it right away
    rdata_q <= (req_i.we && (req_i.waddr == req_i.raddr)) ? req_i.wdata : mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rcmr_ctrl.sv
// Sequencer: request intake, i/j walk over the tables, max accumulate, result register.
module rcmr_ctrl
  import rcmr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [IDX_W-1:0]      price_index_i,
  input  logic [VAL_W-1:0]      price_value_i,
  input  logic [LEN_W-1:0]      rod_length_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [REV_BITS-1:0]   best_revenue_o,
  output price_req_t            price_req_o,
  input  logic [PRICE_BITS-1:0] price_rdata_i,
  output best_req_t             best_req_o,
  input  logic [REV_BITS-1:0]   best_rdata_i
);

  state_e state_q, state_d;

  logic [BADDR_W-1:0]  n_q, i_q, j_q, widx_q;
  logic                issue_q, v_q, last_q, first_q;
  logic [REV_BITS-1:0] res_q;
  logic                out_valid_q;
  logic [REV_BITS-1:0] out_rev_q;

  logic                accept, qry, ld, idx_ok, issue, finish, out_load;
  logic [BADDR_W-1:0]  len_sat;
  logic [SUM_W-1:0]    sum;
  logic [REV_BITS-1:0] cand, q_new;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign qry    = accept && (command_i == CMD_QUERY);
  assign ld     = accept && (command_i == CMD_LOAD);
  assign idx_ok = (int'(price_index_i) >= 1) && (int'(price_index_i) <= int'(MAX_LEN));

  assign len_sat = (int'(rod_length_i) > int'(MAX_LEN)) ? BADDR_W'(MAX_LEN)
                                                        : BADDR_W'(rod_length_i);

  assign issue = (state_q == ST_RUN) && issue_q;

  // best[0] counts as zero: the last cut of a row reads the remainder of length zero
  assign sum   = SUM_W'(price_rdata_i) + SUM_W'(last_q ? '0 : best_rdata_i);
  assign cand  = (sum > SUM_W'(REV_MAX)) ? REV_MAX : sum[REV_BITS-1:0];
  assign q_new = (first_q || (cand > res_q)) ? cand : res_q;

  assign finish   = v_q && last_q && (widx_q == n_q);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (qry) begin
          state_d = (len_sat == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = (state_q != ST_IDLE);
    price_req_o.we    = ld && idx_ok;
    price_req_o.waddr = PADDR_W'(int'(price_index_i) - 1);
    price_req_o.wdata = PRICE_BITS'(price_value_i);
    price_req_o.raddr = PADDR_W'(j_q - BADDR_W'(1));
    best_req_o.we     = v_q && last_q;
    best_req_o.waddr  = widx_q;
    best_req_o.wdata  = q_new;
    best_req_o.raddr  = i_q - j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      v_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= issue;
      if (qry) begin
        issue_q <= 1'b1;
      end else if (issue && (j_q == i_q) && (i_q == n_q)) begin
        issue_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (qry) begin
      n_q   <= len_sat;
      i_q   <= BADDR_W'(1);
      j_q   <= BADDR_W'(1);
      res_q <= '0;
    end else begin
      if (issue) begin
        if (j_q == i_q) begin
          if (i_q != n_q) begin
            i_q <= i_q + BADDR_W'(1);
            j_q <= BADDR_W'(1);
          end
        end else begin
          j_q <= j_q + BADDR_W'(1);
        end
      end
      if (v_q) begin
        res_q <= q_new;
      end
    end
    last_q  <= (j_q == i_q);
    first_q <= (j_q == BADDR_W'(1));
    widx_q  <= i_q;
    if (out_load) begin
      out_rev_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_revenue_o = out_rev_q;

endmodule

// File: rtl/core/rcmr_checker.sv
// Port-level checker for the rod cutting core, bound to the top level.
`include "assert_macros.svh"

module rcmr_checker
  import rcmr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [CMD_W-1:0]    command_i,
  input logic [LEN_W-1:0]    rod_length_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [REV_BITS-1:0] best_revenue_o
);

  logic in_acc;
  logic qry_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign qry_acc = in_acc && (command_i == CMD_QUERY);

  `RCMR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(best_revenue_o))
  `RCMR_ASSERT_NXT(a_busy_after_query, qry_acc && (rod_length_i != '0), in_stall_o)
  `RCMR_ASSERT_IMP(a_zero_len, qry_acc && (rod_length_i == '0) && !out_valid_o, ##2 (out_valid_o && (best_revenue_o == '0)))
  `RCMR_ASSERT_NXT(a_load_silent, in_acc && (command_i == CMD_LOAD) && !out_valid_o, !out_valid_o)

endmodule

bind rod_cutting_max_revenue_core rcmr_checker u_rcmr_checker (.*);
